// ----- hw/rtl/esd_pkg.sv -----
// ---------------------------------------------------------------------------
// esd_pkg: shared types and constants for the escape sequence decoder
// Word formats for both channels, character codes and the hex digit decode.
// ---------------------------------------------------------------------------
package esd_pkg;

   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A_LO  = 8'h61;
   localparam logic [7:0] CH_F_LO  = 8'h66;
   localparam logic [7:0] CH_A_UP  = 8'h41;
   localparam logic [7:0] CH_F_UP  = 8'h46;

   typedef struct packed {
      logic [7:0] ch;
      logic       last_char;
   } esd_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       string_end;
   } esd_rsp_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_digit(input logic [7:0] ch);
      hex_digit_type r;
      logic [7:0]    d;
      r = '0;
      d = '0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         d = ch - CH_ZERO;
         r.valid = 1'b1;
      end else if (ch >= CH_A_LO && ch <= CH_F_LO) begin
         d = ch - CH_A_LO + 8'd10;
         r.valid = 1'b1;
      end else if (ch >= CH_A_UP && ch <= CH_F_UP) begin
         d = ch - CH_A_UP + 8'd10;
         r.valid = 1'b1;
      end
      r.value = d[3:0];
      return r;
   endfunction

   function automatic logic is_octal(input logic [7:0] ch);
      return (ch >= CH_ZERO) && (ch <= CH_SEVEN);
   endfunction

endpackage

// ----- hw/rtl/escape_sequence_decoder.sv -----
// ---------------------------------------------------------------------------
// escape_sequence_decoder: streaming C-style string escape decoder
// Takes one character per word and emits zero, one or two decoded bytes.
// ---------------------------------------------------------------------------
//   channel   direction   payload        words per handshake
//   req_      in          esd_req_type   one source character
//   rsp_      out         esd_rsp_type   one decoded byte or end marker
//
// A character is decoded in the cycle it is accepted; its results sit in a
// four-entry result queue and appear on rsp_ from the next cycle on.
// One character per cycle is taken while the queue has room for two words;
// the output side drains one word per cycle while rsp_ready is high, so
// characters giving two words slow the input to the rate of the output port.
// Synchronous reset returns the decoder to plain copy and empties the queue.
module escape_sequence_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  esd_pkg::esd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output esd_pkg::esd_rsp_type rsp_data
);
   import esd_pkg::*;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_BSL   = 2'd1,
      MODE_HEX   = 2'd2,
      MODE_OCT   = 2'd3
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [8:0] accum_ff, accum_in;
   logic [1:0] dcnt_ff, dcnt_in;

   esd_rsp_type          q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_next;
   logic [RSP_CNT_W-1:0] count_ff, count_in;

   logic          req_fire, rsp_fire;
   hex_digit_type hx;
   logic          emit_esc, do_plain, plain_emit, pending;
   logic [7:0]    esc_val;
   mode_type      mode_step;
   logic [8:0]    accum_step;
   logic [1:0]    dcnt_step;
   esd_rsp_type   res0, res1;
   logic [1:0]    n_res;

   assign req_ready = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_comb begin
      hx         = hex_digit(req_data.ch);
      emit_esc   = 1'b0;
      do_plain   = 1'b0;
      esc_val    = '0;
      mode_step  = mode_ff;
      accum_step = accum_ff;
      dcnt_step  = dcnt_ff;
      case (mode_ff)
         MODE_PLAIN: begin
            do_plain = 1'b1;
         end
         MODE_BSL: begin
            if (req_data.ch == CH_BSL) begin
               emit_esc  = 1'b1;
               esc_val   = CH_BSL;
               mode_step = MODE_PLAIN;
            end else if (req_data.ch == CH_X_LO || req_data.ch == CH_X_UP) begin
               mode_step  = MODE_HEX;
               accum_step = '0;
               dcnt_step  = '0;
            end else if (is_octal(req_data.ch)) begin
               mode_step  = MODE_OCT;
               accum_step = {6'd0, req_data.ch[2:0]};
               dcnt_step  = 2'd1;
            end else begin
               mode_step = MODE_PLAIN;
               do_plain  = 1'b1;
            end
         end
         MODE_HEX: begin
            if (hx.valid) begin
               accum_step = {accum_ff[4:0], hx.value};
               dcnt_step  = dcnt_ff + 2'd1;
               if (dcnt_ff == 2'd1) begin
                  emit_esc  = 1'b1;
                  esc_val   = accum_step[7:0];
                  mode_step = MODE_PLAIN;
               end
            end else begin
               emit_esc  = (dcnt_ff != '0);
               esc_val   = accum_ff[7:0];
               mode_step = MODE_PLAIN;
               do_plain  = 1'b1;
            end
         end
         MODE_OCT: begin
            if (is_octal(req_data.ch)) begin
               accum_step = {accum_ff[5:0], req_data.ch[2:0]};
               dcnt_step  = dcnt_ff + 2'd1;
               if (dcnt_ff == 2'd2) begin
                  emit_esc  = 1'b1;
                  esc_val   = accum_step[7:0];
                  mode_step = MODE_PLAIN;
               end
            end else begin
               emit_esc  = 1'b1;
               esc_val   = accum_ff[7:0];
               mode_step = MODE_PLAIN;
               do_plain  = 1'b1;
            end
         end
         default: begin
            mode_step = MODE_PLAIN;
         end
      endcase

      // a plain backslash opens a new escape instead of emitting
      plain_emit = do_plain && (req_data.ch != CH_BSL);
      if (do_plain && req_data.ch == CH_BSL) begin
         mode_step = MODE_BSL;
      end
      if (mode_step == MODE_PLAIN) begin
         accum_step = '0;
         dcnt_step  = '0;
      end

      // only a step with no output can leave digits pending
      pending = req_data.last_char && (mode_step == MODE_HEX || mode_step == MODE_OCT)
                && (dcnt_step != '0);

      res0 = '0;
      res1 = '0;
      if (emit_esc) begin
         res0.out_byte = esc_val;
         res0.has_byte = 1'b1;
      end else if (plain_emit) begin
         res0.out_byte = req_data.ch;
         res0.has_byte = 1'b1;
      end else if (pending) begin
         res0.out_byte = accum_step[7:0];
         res0.has_byte = 1'b1;
      end
      res1.out_byte = req_data.ch;
      res1.has_byte = 1'b1;

      if (emit_esc && plain_emit) begin
         n_res           = 2'd2;
         res1.string_end = req_data.last_char;
      end else begin
         n_res           = (res0.has_byte || req_data.last_char) ? 2'd1 : 2'd0;
         res0.string_end = req_data.last_char;
      end

      mode_in  = mode_ff;
      accum_in = accum_ff;
      dcnt_in  = dcnt_ff;
      if (req_fire) begin
         if (req_data.last_char) begin
            mode_in  = MODE_PLAIN;
            accum_in = '0;
            dcnt_in  = '0;
         end else begin
            mode_in  = mode_step;
            accum_in = accum_step;
            dcnt_in  = dcnt_step;
         end
      end

      wr_ptr_next = wr_ptr_ff + RSP_PTR_W'(1);
      count_in    = count_ff + (req_fire ? RSP_CNT_W'(n_res) : '0)
                    - (rsp_fire ? RSP_CNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PLAIN;
         accum_ff  <= '0;
         dcnt_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
         dcnt_ff  <= dcnt_in;
         count_ff <= count_in;
         if (req_fire) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(n_res);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
      end
   end

   // queue payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_fire && n_res != 2'd0) begin
         q_ff[wr_ptr_ff] <= res0;
         if (n_res == 2'd2) begin
            q_ff[wr_ptr_next] <= res1;
         end
      end
   end

endmodule

// ----- hw/rtl/esd_checker.sv -----
// ---------------------------------------------------------------------------
// esd_checker: port-level checks for the escape sequence decoder
// Watches both channels and flags malformed result words.
// ---------------------------------------------------------------------------
module esd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input esd_pkg::esd_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input esd_pkg::esd_rsp_type rsp_data
);
   import esd_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // drop everything on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a word without a byte only marks the end of a string
   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_byte |-> rsp_data.string_end
         && rsp_data.out_byte == 8'd0)
      else $error("empty rsp word not at string end");

   // a plain character after a string end comes out as itself when no word is waiting
   a_plain_copy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_char ##1
      req_valid && req_ready && req_data.ch != CH_BSL && !rsp_valid
      |=> rsp_valid && rsp_data.has_byte && rsp_data.out_byte == $past(req_data.ch))
      else $error("plain character not copied");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
